// ----- rtl/diff_drive_odometry_integrator_assert.svh -----
// assertion macros shared by the odometry checker
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_ASSERT_SVH

// same-cycle implication, consequent may open with a delay
`define DDOI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) else $error(msg);

// next-cycle implication
`define DDOI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> cons) else $error(msg);

`endif

// ----- rtl/ddoi_pkg.sv -----
// ----------------------------------------------------------------------------
// ddoi_pkg
// Shared constants, types and helpers for the odometry integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddoi_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int ANG_FRAC     = 30;
  localparam int CORDIC_ITERS = 16;
  localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;
  localparam int RED_W        = 32 + ANG_SHIFT;
  localparam int RED_STEPS    = RED_W - 32;

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef logic signed [33:0] trig_t;
  typedef logic signed [65:0] prod_t;
  typedef logic signed [66:0] wide_t;

  // floored q30 arctangent of 2^-i
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd843314856;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043836;
      5'd3:  r = 32'd133525158;
      5'd4:  r = 32'd67021686;
      5'd5:  r = 32'd33543515;
      5'd6:  r = 32'd16775850;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194282;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048575;
      5'd11: r = 32'd524287;
      5'd12: r = 32'd262143;
      5'd13: r = 32'd131071;
      5'd14: r = 32'd65535;
      5'd15: r = 32'd32767;
      5'd16: r = 32'd16383;
      5'd17: r = 32'd8191;
      5'd18: r = 32'd4095;
      5'd19: r = 32'd2047;
      5'd20: r = 32'd1023;
      5'd21: r = 32'd511;
      5'd22: r = 32'd255;
      5'd23: r = 32'd127;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // out of 32-bit signed range
  function automatic logic sat_ovf(input wide_t x);
    return (x > 67'sd2147483647) || (x < -67'sd2147483648);
  endfunction

  // clamp to 32-bit signed range
  function automatic logic signed [31:0] sat_clamp(input wide_t x);
    logic signed [31:0] r;
    if (x > 67'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ddoi_smul.sv -----
// ----------------------------------------------------------------------------
// ddoi_smul
// Bit-serial signed multiplier, one multiplier bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddoi_smul
  import ddoi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire trig_t a,
  input  wire trig_t b,
  output logic       done,
  output prod_t      prod
);

  logic        run_r;
  logic [4:0]  cnt_r;
  logic [32:0] amag_r;
  logic [65:0] p_r;
  logic        neg_r;
  logic        done_r;
  prod_t       prod_r;

  logic [33:0] amag_full;
  logic [33:0] bmag_full;
  logic [33:0] sum;

  assign amag_full = a[33] ? 34'(-a) : 34'(a);
  assign bmag_full = b[33] ? 34'(-b) : 34'(b);

  // add multiplicand into the high half when the low bit is set
  assign sum = p_r[65:32] + (p_r[0] ? {1'b0, amag_r} : 34'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
        amag_r <= amag_full[32:0];
        p_r    <= {34'd0, bmag_full[31:0]};
        neg_r  <= a[33] ^ b[33];
      end else if (run_r) begin
        p_r    <= {1'b0, sum, p_r[31:1]};
        cnt_r  <= cnt_r + 5'd1;
        done_r <= (cnt_r == 5'd31);
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          prod_r <= neg_r ? -$signed({1'b0, sum, p_r[31:1]})
                          : $signed({1'b0, sum, p_r[31:1]});
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- rtl/ddoi_cordic.sv -----
// ----------------------------------------------------------------------------
// ddoi_cordic
// Heading range reduction by serial subtraction, then rotation-mode cordic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddoi_cordic
  import ddoi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] heading,
  output logic                    done,
  output trig_t                   sin_q30,
  output trig_t                   cos_q30
);

  localparam int KW = $clog2(RED_STEPS);
  localparam logic signed [35:0] TWO_PI36  = $signed({3'b0, TWO_PI_Q30});
  localparam logic signed [35:0] PI36      = $signed({3'b0, PI_Q30});
  localparam logic signed [35:0] HALF_PI36 = $signed({3'b0, HALF_PI_Q30});

  typedef enum logic [2:0] {C_IDLE, C_RED, C_FIX, C_ROT, C_OUT} cstate_t;

  cstate_t            state_r;
  logic [RED_W-1:0]   mag_r;
  logic               neg_r;
  logic [KW-1:0]      k_r;
  logic signed [35:0] z_r;
  trig_t              x_r;
  trig_t              y_r;
  logic               flip_r;
  logic [4:0]         i_r;
  logic               done_r;
  trig_t              sin_r;
  trig_t              cos_r;

  logic signed [RED_W-1:0] a_ext;
  logic [RED_W:0]          tp_sh;
  logic [32:0]             rem;
  logic signed [35:0]      a1, a2, a3;
  logic                    flip;
  trig_t                   dx, dy;
  logic signed [35:0]      at;

  // heading in q30, magnitude for the reduction
  assign a_ext = {heading, {ANG_SHIFT{1'b0}}};
  assign tp_sh = {{(RED_W - 32){1'b0}}, TWO_PI_Q30} << k_r;

  // fold the remainder into [-pi/2, pi/2]
  always_comb begin
    rem  = mag_r[32:0];
    a1   = (neg_r && rem != 33'd0) ? TWO_PI36 - $signed({3'b0, rem})
                                   : $signed({3'b0, rem});
    a2   = (a1 > PI36) ? a1 - TWO_PI36 : a1;
    flip = 1'b0;
    a3   = a2;
    if (a2 > HALF_PI36) begin
      a3   = a2 - PI36;
      flip = 1'b1;
    end else if (a2 < -HALF_PI36) begin
      a3   = a2 + PI36;
      flip = 1'b1;
    end
  end

  // one rotation step
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = $signed({4'b0, atan_q30(i_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == C_OUT);
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            neg_r   <= a_ext[RED_W-1];
            mag_r   <= a_ext[RED_W-1] ? RED_W'(-a_ext) : RED_W'(a_ext);
            k_r     <= KW'(RED_STEPS - 1);
            state_r <= C_RED;
          end
        end
        C_RED: begin
          if ({1'b0, mag_r} >= tp_sh) begin
            mag_r <= mag_r - tp_sh[RED_W-1:0];
          end
          if (k_r == '0) begin
            state_r <= C_FIX;
          end else begin
            k_r <= k_r - 1'b1;
          end
        end
        C_FIX: begin
          z_r     <= a3;
          flip_r  <= flip;
          x_r     <= CORDIC_GAIN_Q30;
          y_r     <= '0;
          i_r     <= '0;
          state_r <= C_ROT;
        end
        C_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(CORDIC_ITERS - 1)) begin
            state_r <= C_OUT;
          end
        end
        C_OUT: begin
          cos_r   <= flip_r ? -x_r : x_r;
          sin_r   <= flip_r ? -y_r : y_r;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign sin_q30 = sin_r;
  assign cos_q30 = cos_r;

endmodule

`default_nettype wire

// ----- rtl/diff_drive_odometry_integrator.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator
// Dead-reckoning pose integrator with explicit and implicit update modes.
// ----------------------------------------------------------------------------
// a reload copies the start registers into the pose state; a step runs range
// reduction and cordic, then the serial multiplier for 5 products explicit,
// 9 implicit; the result waits in T_FIN while the output beat is stalled;
// one item at a time, the next taken only once the result is registered;
// synchronous active-low reset zeroes the state, configuration and pose
// registers and clears the output valid
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_odometry_integrator
  import ddoi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic signed [31:0] in_lin_speed,
  input  wire logic signed [31:0] in_ang_speed,
  input  wire logic [19:0]        in_dt,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pos_x_out,
  output logic signed [31:0]      out_pos_y_out,
  output logic signed [31:0]      out_heading_out,
  output logic signed [31:0]      out_vel_x_out,
  output logic signed [31:0]      out_vel_y_out,
  output logic signed [31:0]      out_omega_out,
  output logic                    out_saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  typedef enum logic [2:0] {T_IDLE, T_TRIG, T_MUL_GO, T_MUL_WAIT, T_FIN} tstate_t;
  typedef enum logic [3:0] {
    M_NVX, M_NVY, M_PX, M_PY, M_HD, M_VDT, M_WDT, M_VW, M_DX1, M_DX2, M_DY1, M_DY2
  } mop_t;
  typedef enum logic [2:0] {
    R_MODE, R_SX, R_SY, R_SH, R_SVX, R_SVY, R_SOM, R_NONE
  } reg_idx_t;

  tstate_t state_r;
  mop_t    mop_r;

  // configuration
  logic               mode_r;
  logic signed [31:0] sx_r, sy_r, sh_r, svx_r, svy_r, som_r;

  // state
  logic signed [31:0] px_r, py_r, hd_r, vx_r, vy_r, tr_r;

  // per-item work registers
  logic signed [31:0] v_r, w_r, nvx_r, nvy_r, vdt_r, wdt_r, vw_r;
  logic [19:0]        dt_r;
  trig_t              sin_r, cos_r;
  logic signed [35:0] tmp_r;
  logic               sat_r;

  // output beat
  logic               ov_r, osat_r;
  logic signed [31:0] opx_r, opy_r, ohd_r, ovx_r, ovy_r, oom_r;

  logic  accept;
  logic  cor_go, cor_done, mul_go, mul_done;
  trig_t cor_sin, cor_cos;
  trig_t op_a, op_b;
  prod_t prod;
  logic [4:0] sh;
  wide_t rnd, half, sum_a, sum_b;
  logic signed [31:0] rnd_c;
  logic               rnd_o;
  logic signed [31:0] sum_a_c;
  logic               sum_a_o;
  logic signed [31:0] sum_b_c;
  logic               sum_b_o;
  logic               out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != T_IDLE);
  assign cfg_ready = 1'b1;
  assign cor_go   = accept && !in_operation;
  assign mul_go   = (state_r == T_MUL_GO);
  assign out_free = !ov_r || !out_stall;

  ddoi_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_go),
    .heading (hd_r),
    .done    (cor_done),
    .sin_q30 (cor_sin),
    .cos_q30 (cor_cos)
  );

  ddoi_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // operand select and rounding shift for each product
  always_comb begin
    op_a = 34'(v_r);
    op_b = cos_r;
    sh   = 5'(ANG_FRAC);
    case (mop_r)
      M_NVX: begin op_a = 34'(v_r); op_b = cos_r; end
      M_NVY: begin op_a = 34'(v_r); op_b = sin_r; end
      M_PX: begin
        op_a = 34'(vx_r) + 34'(nvx_r);
        op_b = $signed({14'd0, dt_r});
        sh   = 5'(FRAC_BITS + 1);
      end
      M_PY: begin
        op_a = 34'(vy_r) + 34'(nvy_r);
        op_b = $signed({14'd0, dt_r});
        sh   = 5'(FRAC_BITS + 1);
      end
      M_HD: begin
        op_a = 34'(tr_r) + 34'(w_r);
        op_b = $signed({14'd0, dt_r});
        sh   = 5'(FRAC_BITS + 1);
      end
      M_VDT: begin
        op_a = 34'(v_r);
        op_b = $signed({14'd0, dt_r});
        sh   = 5'(FRAC_BITS);
      end
      M_WDT: begin
        op_a = 34'(w_r);
        op_b = $signed({14'd0, dt_r});
        sh   = 5'(FRAC_BITS);
      end
      M_VW: begin
        op_a = 34'(vdt_r);
        op_b = 34'(wdt_r);
        sh   = 5'(FRAC_BITS);
      end
      M_DX1: begin op_a = 34'(vdt_r); op_b = cos_r; end
      M_DX2: begin op_a = 34'(vw_r);  op_b = sin_r; end
      M_DY1: begin op_a = 34'(vdt_r); op_b = sin_r; end
      M_DY2: begin op_a = 34'(vw_r);  op_b = cos_r; end
      default: begin op_a = 34'(v_r); op_b = cos_r; end
    endcase
  end

  // round half up, then the sums that land in the state
  always_comb begin
    half  = wide_t'(67'sd1 <<< (sh - 5'd1));
    rnd   = (67'(prod) + half) >>> sh;
    rnd_c = sat_clamp(rnd);
    rnd_o = sat_ovf(rnd);
    sum_a = 67'(px_r) + 67'(hd_r) - 67'(hd_r);
    sum_b = 67'(py_r);
    case (mop_r)
      M_PX:  sum_a = 67'(px_r) + rnd;
      M_PY:  sum_a = 67'(py_r) + rnd;
      M_HD:  sum_a = 67'(hd_r) + rnd;
      M_WDT: sum_a = 67'(hd_r) + 67'(rnd_c);
      M_DX2: sum_a = 67'(px_r) + 67'(tmp_r) - rnd;
      M_DY2: sum_a = 67'(py_r) + 67'(tmp_r) + rnd;
      default: sum_a = 67'(px_r);
    endcase
    sum_b   = sum_a;
    sum_a_c = sat_clamp(sum_a);
    sum_a_o = sat_ovf(sum_a);
    sum_b_c = sat_clamp(sum_b);
    sum_b_o = sat_ovf(sum_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      mop_r   <= M_NVX;
      mode_r  <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      sh_r    <= '0;
      svx_r   <= '0;
      svy_r   <= '0;
      som_r   <= '0;
      px_r    <= '0;
      py_r    <= '0;
      hd_r    <= '0;
      vx_r    <= '0;
      vy_r    <= '0;
      tr_r    <= '0;
      sat_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          R_MODE: mode_r <= cfg_data[0];
          R_SX:   sx_r   <= cfg_data;
          R_SY:   sy_r   <= cfg_data;
          R_SH:   sh_r   <= cfg_data;
          R_SVX:  svx_r  <= cfg_data;
          R_SVY:  svy_r  <= cfg_data;
          R_SOM:  som_r  <= cfg_data;
          R_NONE: ;
          default: ;
        endcase
      end

      // output beat taken, unless a new one replaces it below
      if (ov_r && !out_stall && state_r != T_FIN) begin
        ov_r <= 1'b0;
      end

      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            sat_r <= 1'b0;
            if (in_operation) begin
              px_r    <= sx_r;
              py_r    <= sy_r;
              hd_r    <= sh_r;
              vx_r    <= svx_r;
              vy_r    <= svy_r;
              tr_r    <= som_r;
              state_r <= T_FIN;
            end else begin
              v_r     <= in_lin_speed;
              w_r     <= in_ang_speed;
              dt_r    <= in_dt;
              state_r <= T_TRIG;
            end
          end
        end
        T_TRIG: begin
          if (cor_done) begin
            sin_r   <= cor_sin;
            cos_r   <= cor_cos;
            mop_r   <= M_NVX;
            state_r <= T_MUL_GO;
          end
        end
        T_MUL_GO: begin
          state_r <= T_MUL_WAIT;
        end
        T_MUL_WAIT: begin
          if (mul_done) begin
            case (mop_r)
              M_NVX: begin
                nvx_r   <= rnd_c;
                sat_r   <= sat_r | rnd_o;
                mop_r   <= M_NVY;
                state_r <= T_MUL_GO;
              end
              M_NVY: begin
                nvy_r   <= rnd_c;
                sat_r   <= sat_r | rnd_o;
                mop_r   <= mode_r ? M_VDT : M_PX;
                state_r <= T_MUL_GO;
              end
              M_PX: begin
                px_r    <= sum_a_c;
                sat_r   <= sat_r | sum_a_o;
                mop_r   <= M_PY;
                state_r <= T_MUL_GO;
              end
              M_PY: begin
                py_r    <= sum_a_c;
                sat_r   <= sat_r | sum_a_o;
                mop_r   <= M_HD;
                state_r <= T_MUL_GO;
              end
              M_HD: begin
                hd_r    <= sum_a_c;
                sat_r   <= sat_r | sum_a_o;
                vx_r    <= nvx_r;
                vy_r    <= nvy_r;
                tr_r    <= w_r;
                state_r <= T_FIN;
              end
              M_VDT: begin
                vdt_r   <= rnd_c;
                sat_r   <= sat_r | rnd_o;
                mop_r   <= M_WDT;
                state_r <= T_MUL_GO;
              end
              M_WDT: begin
                wdt_r   <= rnd_c;
                hd_r    <= sum_b_c;
                sat_r   <= sat_r | rnd_o | sum_b_o;
                mop_r   <= M_VW;
                state_r <= T_MUL_GO;
              end
              M_VW: begin
                vw_r    <= rnd_c;
                sat_r   <= sat_r | rnd_o;
                mop_r   <= M_DX1;
                state_r <= T_MUL_GO;
              end
              M_DX1: begin
                tmp_r   <= 36'(rnd);
                mop_r   <= M_DX2;
                state_r <= T_MUL_GO;
              end
              M_DX2: begin
                px_r    <= sum_a_c;
                sat_r   <= sat_r | sum_a_o;
                mop_r   <= M_DY1;
                state_r <= T_MUL_GO;
              end
              M_DY1: begin
                tmp_r   <= 36'(rnd);
                mop_r   <= M_DY2;
                state_r <= T_MUL_GO;
              end
              M_DY2: begin
                py_r    <= sum_a_c;
                sat_r   <= sat_r | sum_a_o;
                vx_r    <= nvx_r;
                vy_r    <= nvy_r;
                tr_r    <= w_r;
                state_r <= T_FIN;
              end
              default: state_r <= T_FIN;
            endcase
          end
        end
        T_FIN: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            opx_r   <= px_r;
            opy_r   <= py_r;
            ohd_r   <= hd_r;
            ovx_r   <= vx_r;
            ovy_r   <= vy_r;
            oom_r   <= tr_r;
            osat_r  <= sat_r;
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_pos_x_out   = opx_r;
  assign out_pos_y_out   = opy_r;
  assign out_heading_out = ohd_r;
  assign out_vel_x_out   = ovx_r;
  assign out_vel_y_out   = ovy_r;
  assign out_omega_out   = oom_r;
  assign out_saturated   = osat_r;

endmodule

`default_nettype wire

// ----- rtl/ddoi_checker.sv -----
// ----------------------------------------------------------------------------
// ddoi_checker
// Port-level checks on the odometry integrator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "diff_drive_odometry_integrator_assert.svh"

module ddoi_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_operation,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_pos_x_out,
  input wire logic        out_saturated
);

  // a stalled result beat stays
  `DDOI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "beat dropped")

  // a stalled result beat keeps its x position
  `DDOI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_pos_x_out), "payload moved")

  // one item at a time: busy right after a beat in
  `DDOI_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after beat")

  // a reload with no beat waiting passes through T_FIN into the output register and never saturates
  `DDOI_ASSERT_IMP(a_reload, clk, rst_n, in_valid && !in_stall && in_operation && !out_valid, ##2 (out_valid && !out_saturated), "reload beat wrong")

endmodule

bind diff_drive_odometry_integrator ddoi_checker u_ddoi_checker (.*);

`default_nettype wire

// ----- bench/ddoi_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// ddoi_tb_pkg
// Register indexes, operation codes and the pose record shared by the
// odometry integrator testbench and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddoi_tb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_START_X     = 3'd1;
  localparam logic [2:0] REG_START_Y     = 3'd2;
  localparam logic [2:0] REG_START_HEAD  = 3'd3;
  localparam logic [2:0] REG_START_VX    = 3'd4;
  localparam logic [2:0] REG_START_VY    = 3'd5;
  localparam logic [2:0] REG_START_OMEGA = 3'd6;
  localparam logic [2:0] REG_UNUSED      = 3'd7;

  // operations and integration modes
  localparam logic OP_STEP        = 1'b0;
  localparam logic OP_RELOAD      = 1'b1;
  localparam logic MODE_EXPLICIT  = 1'b0;
  localparam logic MODE_IMPLICIT  = 1'b1;

  // one result beat
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] hd;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] om;
    logic               sat;
  } pose_t;

endpackage

// ----- bench/odometry_checker.sv -----
// ----------------------------------------------------------------------------
// odometry_checker
// Watches the configuration, input and result channels of the odometry
// integrator, predicts every pose update in Q16.16 and compares each
// result beat field by field against the oldest predicted pose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module odometry_checker
  import ddoi_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_lin_speed,
  input  logic signed [31:0] in_ang_speed,
  input  logic [19:0]        in_dt,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_pos_x_out,
  input  logic signed [31:0] out_pos_y_out,
  input  logic signed [31:0] out_heading_out,
  input  logic signed [31:0] out_vel_x_out,
  input  logic signed [31:0] out_vel_y_out,
  input  logic signed [31:0] out_omega_out,
  input  logic               out_saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam int     FRAC        = 16;
  localparam int     ANG         = 30;
  localparam int     ITERS       = 16;

  localparam longint ARCTAN_Q30 [ITERS] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  // shadow registers and pose state
  logic   mode_q;
  longint start_x, start_y, start_hd, start_vx, start_vy, start_om;
  longint pos_x, pos_y, head, vel_x, vel_y, omega;
  pose_t  expected_poses [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint clamp32(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // round to nearest, ties up
  function automatic longint mul_rnd(input longint a, input longint b, input int n);
    return (a * b + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // range-reduced rotation cordic, q2.30 results
  function automatic void heading_trig(input longint h, output longint s,
                                       output longint c);
    longint a, x, y, z, dx, dy;
    logic   flip;
    a = (h * 64'sd16384) % TWO_PI_Q30;
    if (a < 0) a += TWO_PI_Q30;
    if (a > PI_Q30) a -= TWO_PI_Q30;
    flip = 1'b0;
    if (a > HALF_PI_Q30) begin
      a -= PI_Q30;
      flip = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      a += PI_Q30;
      flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    z = a;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q30[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // advance the pose by one input beat
  function automatic pose_t odometry_advance(input logic op, input longint v,
                                             input longint w, input longint dt);
    pose_t  r;
    logic   sat;
    longint s, c, nvx, nvy, vdt, wdt, vw, dx, dy;
    sat = 1'b0;
    if (op == OP_RELOAD) begin
      pos_x = start_x;  pos_y = start_y;  head  = start_hd;
      vel_x = start_vx; vel_y = start_vy; omega = start_om;
    end else begin
      heading_trig(head, s, c);
      nvx = clamp32(mul_rnd(v, c, ANG), sat);
      nvy = clamp32(mul_rnd(v, s, ANG), sat);
      if (mode_q == MODE_EXPLICIT) begin
        pos_x = clamp32(pos_x + mul_rnd(vel_x + nvx, dt, FRAC + 1), sat);
        pos_y = clamp32(pos_y + mul_rnd(vel_y + nvy, dt, FRAC + 1), sat);
        head  = clamp32(head + mul_rnd(omega + w, dt, FRAC + 1), sat);
      end else begin
        vdt = clamp32(mul_rnd(v, dt, FRAC), sat);
        wdt = clamp32(mul_rnd(w, dt, FRAC), sat);
        vw  = clamp32(mul_rnd(vdt, wdt, FRAC), sat);
        dx  = mul_rnd(vdt, c, ANG) - mul_rnd(vw, s, ANG);
        dy  = mul_rnd(vdt, s, ANG) + mul_rnd(vw, c, ANG);
        pos_x = clamp32(pos_x + dx, sat);
        pos_y = clamp32(pos_y + dy, sat);
        head  = clamp32(head + wdt, sat);
      end
      vel_x = nvx;
      vel_y = nvy;
      omega = w;
    end
    r.px = pos_x[31:0]; r.py = pos_y[31:0]; r.hd = head[31:0];
    r.vx = vel_x[31:0]; r.vy = vel_y[31:0]; r.om = omega[31:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // sample all channels on the rising edge
  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      mode_q = MODE_EXPLICIT;
      start_x = 0; start_y = 0; start_hd = 0;
      start_vx = 0; start_vy = 0; start_om = 0;
      pos_x = 0; pos_y = 0; head = 0;
      vel_x = 0; vel_y = 0; omega = 0;
      expected_poses.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("beat with nothing expected", out_pos_x_out, 0);
        end else begin
          e = expected_poses.pop_front();
          if (out_pos_x_out !== e.px) report_mismatch("pos_x", out_pos_x_out, e.px);
          if (out_pos_y_out !== e.py) report_mismatch("pos_y", out_pos_y_out, e.py);
          if (out_heading_out !== e.hd) report_mismatch("heading", out_heading_out, e.hd);
          if (out_vel_x_out !== e.vx) report_mismatch("vel_x", out_vel_x_out, e.vx);
          if (out_vel_y_out !== e.vy) report_mismatch("vel_y", out_vel_y_out, e.vy);
          if (out_omega_out !== e.om) report_mismatch("omega", out_omega_out, e.om);
          if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:        mode_q   = cfg_data[0];
          REG_START_X:     start_x  = longint'(signed'(cfg_data));
          REG_START_Y:     start_y  = longint'(signed'(cfg_data));
          REG_START_HEAD:  start_hd = longint'(signed'(cfg_data));
          REG_START_VX:    start_vx = longint'(signed'(cfg_data));
          REG_START_VY:    start_vy = longint'(signed'(cfg_data));
          REG_START_OMEGA: start_om = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      // accepted input beat
      if (in_valid && !in_stall) begin
        expected_poses.push_back(odometry_advance(in_operation, longint'(in_lin_speed),
                                                  longint'(in_ang_speed),
                                                  longint'({1'b0, in_dt})));
      end
    end
    pending = expected_poses.size();
  end

endmodule

// ----- bench/diff_drive_odometry_integrator_tb.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_tb
// Drives directed and random odometry steps and reloads through the
// integrator under several register settings and idling patterns; the
// checker predicts each pose and the top reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_odometry_integrator_tb;
  import ddoi_tb_pkg::*;

  localparam int CHUNKS     = 6;
  localparam int CHUNK_ITEMS = 125;
  localparam int HOLD_CYCLES = 600;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_operation;
  logic signed [31:0] in_lin_speed;
  logic signed [31:0] in_ang_speed;
  logic [19:0]        in_dt;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_pos_x_out;
  logic signed [31:0] out_pos_y_out;
  logic signed [31:0] out_heading_out;
  logic signed [31:0] out_vel_x_out;
  logic signed [31:0] out_vel_y_out;
  logic signed [31:0] out_omega_out;
  logic               out_saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 fail_count;
  int                 pending;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;

  diff_drive_odometry_integrator dut (.*);

  odometry_checker checker_i (.*);

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial begin
    #30ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall, plus one long hold-off counted here
  initial begin
    int   hold_cnt;
    logic hold_taken;
    hold_cnt   = 0;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cnt   = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        out_stall = 1'b1;
        hold_cnt--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // one input beat, called and returning on a falling edge
  task automatic send_beat(input logic op, input logic signed [31:0] v,
                           input logic signed [31:0] w, input logic [19:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_lin_speed = v;
    in_ang_speed = w;
    in_dt        = dt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop offering and let every predicted pose come back
  task automatic drain;
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_starts(input logic mode, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] h, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [31:0] om);
    write_reg(REG_MODE, {31'd0, mode});
    write_reg(REG_START_X, x);
    write_reg(REG_START_Y, y);
    write_reg(REG_START_HEAD, h);
    write_reg(REG_START_VX, vx);
    write_reg(REG_START_VY, vy);
    write_reg(REG_START_OMEGA, om);
  endtask

  // mostly plausible motion, some full-range noise and reloads
  task automatic send_random;
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      send_beat(OP_RELOAD, $urandom, $urandom, $urandom_range(0, 1048575));
    end else if (r < 20) begin
      send_beat(OP_STEP, $urandom, $urandom, $urandom_range(0, 1048575));
    end else begin
      send_beat(OP_STEP, int'($urandom_range(0, 2097152)) - 1048576,
                int'($urandom_range(0, 524288)) - 262144, $urandom_range(0, 16384));
    end
  endtask

  task automatic directed_steps;
    send_beat(OP_RELOAD, 32'sd0, 32'sd0, 20'd0);
    send_beat(OP_STEP, 32'sh0001_0000, 32'sd0, 20'h1_0000);
    send_beat(OP_STEP, 32'sh0002_0000, 32'sh0000_8000, 20'h0_4000);
    send_beat(OP_STEP, 32'sh7fff_ffff, 32'sh7fff_ffff, 20'hf_ffff);
    send_beat(OP_STEP, 32'sh8000_0000, 32'sh8000_0000, 20'hf_ffff);
    send_beat(OP_STEP, -32'sh0001_0000, -32'sh0003_2440, 20'd0);
    send_beat(OP_STEP, 32'sh0001_0000, 32'sh0003_2440, 20'h1_0000);
    send_beat(OP_STEP, 32'sh0000_0001, -32'sd1, 20'd1);
    send_beat(OP_RELOAD, 32'sh7fff_ffff, 32'sh8000_0000, 20'hf_ffff);
  endtask

  initial begin
    logic [31:0] sv;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_STEP;
    in_lin_speed  = '0;
    in_ang_speed  = '0;
    in_dt         = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MODE;
    cfg_data      = '0;
    hold_req      = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 45;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: explicit from zero, implicit with heading near pi, extreme starts
    write_reg(REG_UNUSED, 32'hdead_beef);
    directed_steps();
    drain();
    write_starts(MODE_IMPLICIT, 32'sd0, 32'sd0, 32'h0003_2440, 32'd0, 32'd0, 32'd0);
    directed_steps();
    drain();
    write_starts(MODE_EXPLICIT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(OP_RELOAD, 32'sd0, 32'sd0, 20'd0);
    send_beat(OP_STEP, 32'sh0100_0000, 32'sh0001_0000, 20'h1_0000);

    // random phases, each with its own register setting
    for (int k = 0; k < CHUNKS; k++) begin
      drain();
      case (k / 2)
        0: begin send_idle_pct = 36; recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (k)
        0: write_starts(MODE_EXPLICIT, 0, 0, 0, 0, 0, 0);
        1: write_starts(MODE_IMPLICIT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        2: write_starts(MODE_EXPLICIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        default: begin
          sv = $urandom;
          write_starts(k[0] ? MODE_IMPLICIT : MODE_EXPLICIT, $urandom_range(0, 2097152),
                       sv, $urandom, $urandom, $urandom, $urandom);
        end
      endcase
      send_beat(OP_RELOAD, $urandom, $urandom, $urandom_range(0, 1048575));
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        // long receiver hold-off while inputs keep coming
        if (k == 1 && i == 40) hold_req = 1'b1;
        send_random();
      end
    end

    // wind down
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ddoi_pkg.sv
rtl/ddoi_smul.sv
rtl/ddoi_cordic.sv
rtl/diff_drive_odometry_integrator.sv
rtl/ddoi_checker.sv
bench/ddoi_tb_pkg.sv
bench/odometry_checker.sv
bench/diff_drive_odometry_integrator_tb.sv
